>>> design/cfta_pkg.sv
// cfta_pkg: shared types, codes and sizes of the cutset failure timeline analyzer.
// Used by cfta_ctrl, cfta_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package cfta_pkg;
   localparam int MaxComponents = 64;
   localparam int MaxCutsets = 32;
   localparam int TimeBits = 32;
   localparam int CompBits = 6;
   localparam int CutBits = 5;
   localparam int CountBits = 7;
   localparam logic [CountBits-1:0] CountMax = 7'd127;
   localparam logic [15:0] FailsMax = 16'hFFFF;

   localparam logic [2:0] KindStart = 3'd0;
   localparam logic [2:0] KindEvent = 3'd1;
   localparam logic [2:0] KindMember = 3'd2;
   localparam logic [2:0] KindSize = 3'd3;
   localparam logic [2:0] KindEnd = 3'd4;

   localparam logic [1:0] EvFail = 2'd1;
   localparam logic [1:0] EvRepair = 2'd2;

   localparam logic CsrMission = 1'b0;
   localparam logic CsrFirstOnly = 1'b1;

   typedef enum logic [2:0] {
      StIdle,
      StClear,
      StFetch,
      StWalk,
      StOut
   } state_type;

   typedef struct packed {
      logic start;      // reset trial accumulators
      logic clear_step; // clear one failed-member entry (index = walk index)
      logic fetch;      // latch request, read membership row
      logic walk_step;  // process cutset at walk index
      logic load_member;
      logic load_size;
      logic emit_end;   // build end-of-trial result
   } cmd_type;

   typedef struct packed {
      logic walk_last;  // walk index at final cutset
      logic ffo_hit;    // first-failure report produced this step
      logic trial_done;
   } status_type;
endpackage

>>> design/cfta_datapath.sv
// cfta_datapath: tables, counters and time accumulators of the analyzer.
// Depends on cfta_pkg; driven by cfta_ctrl commands.
`timescale 1ns / 1ps
module cfta_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  cfta_pkg::cmd_type                 cmd,
   output cfta_pkg::status_type              status,
   input  logic [cfta_pkg::TimeBits-1:0]     mission,
   input  logic                              first_only,
   input  logic [1:0]                        req_event_type,
   input  logic [5:0]                        req_component,
   input  logic [31:0]                       req_event_time,
   input  logic [31:0]                       req_member_mask,
   input  logic [4:0]                        req_cutset,
   input  logic [6:0]                        req_cutset_size,
   output logic                              res_system_failed,
   output logic [15:0]                       res_failure_count,
   output logic [31:0]                       res_uptime,
   output logic [31:0]                       res_downtime,
   output logic [31:0]                       res_first_failure_time,
   output logic                              res_operating_at_end
);
   localparam int TB = cfta_pkg::TimeBits;
   localparam int NC = cfta_pkg::MaxCutsets;

   logic [31:0] member_mem [cfta_pkg::MaxComponents];
   logic [6:0]  size_mem [NC];
   logic [6:0]  count_ff [NC];

   logic [31:0] row_ff;
   logic [1:0]  etype_ff;
   logic [TB-1:0] t_ff;
   logic [4:0]  idx_ff;
   logic        down_ff, cvalid_ff, done_ff, upend_ff;
   logic [4:0]  cause_ff;
   logic [15:0] fails_ff;
   logic [TB-1:0] up_ff, dn_ff, lfail_ff, lrep_ff, tup_ff, tdn_ff, ffirst_ff;

   function automatic logic [TB-1:0] tsub(input logic [TB-1:0] a, input logic [TB-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction
   function automatic logic [TB-1:0] tadd(input logic [TB-1:0] a, input logic [TB-1:0] b);
      logic [TB:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TB] ? '1 : s[TB-1:0];
   endfunction

   // per-cutset step, combinational on current walk index
   logic [6:0] cnt, cnt_new, sz;
   logic       member, restore, fail_now, down_mid;
   logic [TB-1:0] rep_mid;
   always_comb begin
      cnt = count_ff[idx_ff];
      sz = size_mem[idx_ff];
      member = row_ff[idx_ff];
      restore = member && cvalid_ff && cause_ff == idx_ff && cnt == sz
         && etype_ff == cfta_pkg::EvRepair;
      cnt_new = cnt;
      if (etype_ff == cfta_pkg::EvFail && cnt < cfta_pkg::CountMax) cnt_new = cnt + 7'd1;
      else if (etype_ff == cfta_pkg::EvRepair && cnt != 7'd0) cnt_new = cnt - 7'd1;
      down_mid = restore ? 1'b0 : down_ff;
      // a restore in this step moves the repair mark before the failure check
      rep_mid = restore ? t_ff : lrep_ff;
      fail_now = member && !down_mid && cnt_new == sz;
   end

   assign status.walk_last = (idx_ff == 5'(NC - 1));
   assign status.ffo_hit = fail_now && fails_ff == 16'd0 && first_only;
   assign status.trial_done = done_ff;

   logic [TB-1:0] t_req;
   assign t_req = (req_event_time > mission) ? mission : req_event_time;

   always_ff @(posedge clock) begin
      if (cmd.load_member) member_mem[req_component] <= req_member_mask;
      if (cmd.load_size) size_mem[req_cutset] <= req_cutset_size;
      if (cmd.fetch) begin
         row_ff <= member_mem[req_component];
         etype_ff <= req_event_type;
         t_ff <= t_req;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) count_ff[idx_ff] <= '0;
      if (cmd.walk_step && member) count_ff[idx_ff] <= cnt_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         down_ff <= 1'b0; cvalid_ff <= 1'b0; cause_ff <= '0; fails_ff <= '0;
         up_ff <= mission; dn_ff <= '0; lfail_ff <= '0; lrep_ff <= '0;
         tup_ff <= '0; tdn_ff <= '0; ffirst_ff <= mission;
         done_ff <= 1'b0; upend_ff <= 1'b1;
      end else begin
         if (cmd.start) begin
            idx_ff <= '0;
            down_ff <= 1'b0; cvalid_ff <= 1'b0; cause_ff <= '0; fails_ff <= '0;
            up_ff <= mission; dn_ff <= '0; lfail_ff <= '0; lrep_ff <= '0;
            tup_ff <= '0; tdn_ff <= '0; ffirst_ff <= mission;
            done_ff <= 1'b0; upend_ff <= 1'b1;
         end
         if (cmd.clear_step || cmd.walk_step) idx_ff <= idx_ff + 5'd1;
         if (cmd.fetch) idx_ff <= '0;
         if (cmd.emit_end) begin
            done_ff <= 1'b1;
            res_system_failed <= fails_ff != 16'd0;
            res_failure_count <= fails_ff;
            res_uptime <= tadd(up_ff, tup_ff);
            res_downtime <= tadd(dn_ff, tdn_ff);
            res_first_failure_time <= ffirst_ff;
            res_operating_at_end <= upend_ff;
         end
         if (cmd.walk_step) begin
            if (restore) begin
               down_ff <= 1'b0;
               dn_ff <= tadd(dn_ff, tsub(t_ff, lfail_ff));
               tdn_ff <= '0;
               lrep_ff <= t_ff;
               tup_ff <= tsub(mission, t_ff);
               upend_ff <= 1'b1;
            end
            if (fail_now) begin
               if (fails_ff != cfta_pkg::FailsMax) fails_ff <= fails_ff + 16'd1;
               down_ff <= 1'b1; cvalid_ff <= 1'b1; cause_ff <= idx_ff;
               lfail_ff <= t_ff;
               up_ff <= (fails_ff == 16'd0) ? t_ff
                  : tadd(up_ff, tsub(t_ff, rep_mid));
               tdn_ff <= tsub(mission, t_ff);
               tup_ff <= '0;
               upend_ff <= 1'b0;
               if (fails_ff == 16'd0) begin
                  ffirst_ff <= t_ff;
                  if (first_only) begin
                     done_ff <= 1'b1;
                     res_system_failed <= 1'b1;
                     res_failure_count <= 16'd1;
                     res_uptime <= t_ff;
                     res_downtime <= tsub(mission, t_ff);
                     res_first_failure_time <= t_ff;
                     res_operating_at_end <= 1'b0;
                  end
               end
            end
         end
      end
   end
endmodule

>>> design/cfta_ctrl.sv
// cfta_ctrl: request sequencer of the analyzer.
// Depends on cfta_pkg; issues commands to cfta_datapath.
`timescale 1ns / 1ps
module cfta_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_kind,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  cfta_pkg::status_type status,
   output cfta_pkg::cmd_type    cmd
);
   cfta_pkg::state_type state_ff, state_in;
   logic rsp_ff, rsp_in;
   logic acc;

   assign rsp_valid = rsp_ff;
   assign req_stall = (state_ff != cfta_pkg::StIdle) || rsp_ff;
   assign acc = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfta_pkg::StIdle;
         rsp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_in = rsp_ff && rsp_stall;
      cmd = '0;
      unique case (state_ff)
         cfta_pkg::StIdle: begin
            if (acc) begin
               unique case (req_kind)
                  cfta_pkg::KindStart: begin
                     cmd.start = 1'b1;
                     state_in = cfta_pkg::StClear;
                  end
                  cfta_pkg::KindEvent: begin
                     if (!status.trial_done) begin
                        cmd.fetch = 1'b1;
                        state_in = cfta_pkg::StWalk;
                     end
                  end
                  cfta_pkg::KindMember: cmd.load_member = 1'b1;
                  cfta_pkg::KindSize: cmd.load_size = 1'b1;
                  cfta_pkg::KindEnd: begin
                     if (!status.trial_done) begin
                        cmd.emit_end = 1'b1;
                        rsp_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         cfta_pkg::StClear: begin
            cmd.clear_step = 1'b1;
            if (status.walk_last) state_in = cfta_pkg::StIdle;
         end
         cfta_pkg::StWalk: begin
            cmd.walk_step = 1'b1;
            if (status.ffo_hit) begin
               rsp_in = 1'b1;
               state_in = cfta_pkg::StIdle;
            end else if (status.walk_last) state_in = cfta_pkg::StIdle;
         end
         default: state_in = cfta_pkg::StIdle;
      endcase
   end
endmodule

>>> design/cutset_failure_timeline_analyzer.sv
// Cutset failure timeline analyzer: a Monte Carlo trial evaluator for minimal cutsets.
// Top level; instantiates cfta_ctrl and cfta_datapath; types from cfta_pkg.
//
// Use: load membership rows (kind 2) and cutset sizes (kind 3), then send a
// start trial (kind 0), time-sorted component events (kind 1) and end trial
// (kind 4). A result request leaves on rsp_ at end of trial, or at the first
// system failure when first_failure_only is set.
// Request channel: req_valid / req_stall; a request is taken when valid is
// high and stall low. Result channel: rsp_valid / rsp_stall, same rule.
// Operation: a load is written when it is taken. A start trial resets the
// accumulators, then sweeps the failed-member counters clear one cutset at a
// time. A component event reads the membership row, then walks the cutsets one
// at a time through the shared count/compare/accumulate step; a first-failure
// report ends the walk early. A result is registered and shows in the cycle
// after the deciding step; while it is valid, including every cycle that
// rsp_stall stays high, no new request is taken.
// Reset (synchronous, active high) sets mission_time to all ones and
// first_failure_only to 0, then the block runs a start trial by itself, so
// req_stall stays high until its clear sweep is done. Tables are undefined until written.
`timescale 1ns / 1ps
module cutset_failure_timeline_analyzer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [5:0]  req_component,
   input  logic [1:0]  req_event_type,
   input  logic [31:0] req_event_time,
   input  logic [31:0] req_member_mask,
   input  logic [4:0]  req_cutset,
   input  logic [6:0]  req_cutset_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_system_failed,
   output logic [15:0] rsp_failure_count,
   output logic [31:0] rsp_uptime,
   output logic [31:0] rsp_downtime,
   output logic [31:0] rsp_first_failure_time,
   output logic        rsp_operating_at_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   logic [31:0] mission_ff;
   logic        first_only_ff;
   cfta_pkg::cmd_type    cmd;
   cfta_pkg::status_type status;
   logic clr_count_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mission_ff <= '1;
         first_only_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            cfta_pkg::CsrMission: mission_ff <= csr_data;
            cfta_pkg::CsrFirstOnly: first_only_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // counters are cleared by issuing a start trial right after reset
   always_ff @(posedge clock) begin
      if (reset) clr_count_ff <= 1'b1;
      else clr_count_ff <= 1'b0;
   end

   logic req_valid_int;
   logic [2:0] req_kind_int;
   logic stall_int;
   assign req_valid_int = req_valid || clr_count_ff;
   assign req_kind_int = clr_count_ff ? cfta_pkg::KindStart : req_kind;
   assign req_stall = stall_int || clr_count_ff;

   cfta_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid_int), .req_stall(stall_int), .req_kind(req_kind_int),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd)
   );

   cfta_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .mission(mission_ff), .first_only(first_only_ff),
      .req_event_type(req_event_type), .req_component(req_component),
      .req_event_time(req_event_time), .req_member_mask(req_member_mask),
      .req_cutset(req_cutset), .req_cutset_size(req_cutset_size),
      .res_system_failed(rsp_system_failed), .res_failure_count(rsp_failure_count),
      .res_uptime(rsp_uptime), .res_downtime(rsp_downtime),
      .res_first_failure_time(rsp_first_failure_time),
      .res_operating_at_end(rsp_operating_at_end)
   );
endmodule
